[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion with reset disable
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication that must hold in the cycle after its antecedent
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

[src/cpu8_pkg.sv]
// types and opcode constants for the instruction execute core
package cpu8_pkg;
	localparam logic [7:0] OP_NOP    = 8'h00;
	localparam logic [7:0] OP_LD_AN  = 8'h3E;
	localparam logic [7:0] OP_JR     = 8'h18;
	localparam logic [7:0] OP_LD_SP  = 8'h31;
	localparam logic [7:0] OP_HALT   = 8'h76;
	localparam logic [7:0] OP_LD_AM  = 8'h7E;
	localparam logic [7:0] OP_JP     = 8'hC3;
	localparam logic [7:0] OP_JP_HL  = 8'hE9;
	localparam logic [7:0] OP_XOR_N  = 8'hEE;
	localparam logic [2:0] R_MEM     = 3'd6;
	localparam logic [3:0] FLAG_Z    = 4'h8;
	localparam logic [3:0] FLAG_H    = 4'h2;
	localparam logic [3:0] FLAG_C    = 4'h1;
	localparam logic       ST_OK     = 1'b0;
	localparam logic       ST_UNSUP  = 1'b1;

	typedef struct packed {
		logic [7:0]  opcode;
		logic [15:0] immediate;
		logic [7:0]  mem_data;
	} instr_t;

	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  d;
		logic [7:0]  e;
		logic [7:0]  h;
		logic [7:0]  l;
		logic [3:0]  f;
		logic [15:0] pc;
		logic [15:0] sp;
	} regs_t;

	typedef struct packed {
		logic        status;
		logic [15:0] next_pc;
		logic [7:0]  a_value;
		logic [3:0]  flags_value;
		logic [15:0] bc_value;
		logic [15:0] de_value;
		logic [15:0] hl_value;
		logic [15:0] sp_value;
		logic        mem_write;
		logic [7:0]  mem_write_data;
		logic [2:0]  machine_cycles;
	} result_t;
endpackage

[src/cpu8_stream_if.sv]
// valid/ready channel carrying one word
interface cpu8_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[src/cpu8_exec.sv]
// combinational execute of one instruction against the register state
module cpu8_exec import cpu8_pkg::*; (
	input  instr_t  ins,
	input  regs_t   cur,
	output regs_t   nxt,
	output result_t res
);
	function automatic logic [7:0] get_reg(regs_t r, logic [2:0] code, logic [7:0] m);
		case (code)
			3'd0: get_reg = r.b;
			3'd1: get_reg = r.c;
			3'd2: get_reg = r.d;
			3'd3: get_reg = r.e;
			3'd4: get_reg = r.h;
			3'd5: get_reg = r.l;
			3'd6: get_reg = m;
			default: get_reg = r.a;
		endcase
	endfunction

	function automatic regs_t set_reg(regs_t r, logic [2:0] code, logic [7:0] v);
		regs_t o;
		o = r;
		case (code)
			3'd0: o.b = v;
			3'd1: o.c = v;
			3'd2: o.d = v;
			3'd3: o.e = v;
			3'd4: o.h = v;
			3'd5: o.l = v;
			3'd6: o.b = r.b;
			default: o.a = v;
		endcase
		return o;
	endfunction

	function automatic logic cond(logic [3:0] f, logic [1:0] cc);
		case (cc)
			2'd0: cond = !f[3];
			2'd1: cond = f[3];
			2'd2: cond = !f[0];
			default: cond = f[0];
		endcase
	endfunction

	logic [7:0]  op, n, src, incv, lres;
	logic [15:0] pc1, pc2, pc3, hl, bc1, de1, hl1, rel;
	logic [2:0]  rd, rs;
	logic [3:0]  incf;
	logic [1:0]  kind;

	always_comb begin
		op   = ins.opcode;
		n    = ins.immediate[7:0];
		rd   = op[5:3];
		rs   = op[2:0];
		hl   = {cur.h, cur.l};
		pc1  = cur.pc + 16'd1;
		pc2  = cur.pc + 16'd2;
		pc3  = cur.pc + 16'd3;
		bc1  = {cur.b, cur.c} + 16'd1;
		de1  = {cur.d, cur.e} + 16'd1;
		hl1  = hl + 16'd1;
		rel  = pc2 + {{8{n[7]}}, n};
		src  = (op[7:6] == 2'b00) ? get_reg(cur, rd, ins.mem_data)
			: get_reg(cur, rs, ins.mem_data);
		incv = src + 8'd1;
		incf = (cur.f & FLAG_C) | ((incv == 8'd0) ? FLAG_Z : 4'h0)
			| ((src[3:0] == 4'hF) ? FLAG_H : 4'h0);
		kind = (op == OP_XOR_N) ? 2'd1 : (op < 8'hA8) ? 2'd0 : (op < 8'hB0) ? 2'd1 : 2'd2;
		case (kind)
			2'd0: lres = cur.a & ((op == OP_XOR_N) ? n : src);
			2'd1: lres = cur.a ^ ((op == OP_XOR_N) ? n : src);
			default: lres = cur.a | src;
		endcase

		nxt = cur;
		nxt.pc = pc1;
		res = '0;
		res.status = ST_OK;
		res.machine_cycles = 3'd1;

		if (op == OP_NOP) begin
			res.machine_cycles = 3'd1;
		end else if ((op & 8'hCF) == 8'h03) begin
			case (op[5:4])
				2'd0: {nxt.b, nxt.c} = bc1;
				2'd1: {nxt.d, nxt.e} = de1;
				2'd2: {nxt.h, nxt.l} = hl1;
				default: nxt.sp = cur.sp + 16'd1;
			endcase
			res.machine_cycles = 3'd2;
		end else if ((op & 8'hC7) == 8'h04) begin
			nxt.f = incf;
			if (rd == R_MEM) begin
				res.mem_write = 1'b1;
				res.mem_write_data = incv;
				res.machine_cycles = 3'd3;
			end else begin
				nxt = set_reg(nxt, rd, incv);
			end
		end else if ((op & 8'hC7) == 8'h06 && op != OP_LD_AN) begin
			nxt.pc = pc2;
			if (rd == R_MEM) begin
				res.mem_write = 1'b1;
				res.mem_write_data = n;
				res.machine_cycles = 3'd3;
			end else begin
				nxt = set_reg(nxt, rd, n);
				res.machine_cycles = 3'd2;
			end
		end else if (op == OP_JR || (op & 8'hE7) == 8'h20) begin
			nxt.pc = (op == OP_JR || cond(cur.f, op[4:3])) ? rel : pc2;
			res.machine_cycles = 3'd2;
		end else if (op == OP_LD_SP) begin
			nxt.sp = ins.immediate;
			nxt.pc = pc3;
			res.machine_cycles = 3'd3;
		end else if (op[7:6] == 2'b01 && op != OP_HALT && op != OP_LD_AM) begin
			if (rd == R_MEM) begin
				res.mem_write = 1'b1;
				res.mem_write_data = src;
				res.machine_cycles = 3'd2;
			end else begin
				nxt = set_reg(nxt, rd, src);
				res.machine_cycles = (rs == R_MEM) ? 3'd2 : 3'd1;
			end
		end else if ((op >= 8'hA0 && op <= 8'hB7) || op == OP_XOR_N) begin
			nxt.a = lres;
			nxt.f = ((lres == 8'd0) ? FLAG_Z : 4'h0) | ((kind == 2'd0) ? FLAG_H : 4'h0);
			if (op == OP_XOR_N) begin
				nxt.pc = pc2;
				res.machine_cycles = 3'd2;
			end else begin
				res.machine_cycles = (rs == R_MEM) ? 3'd2 : 3'd1;
			end
		end else if (op == OP_JP || (op & 8'hE7) == 8'hC2) begin
			nxt.pc = (op == OP_JP || cond(cur.f, op[4:3])) ? ins.immediate : pc3;
			res.machine_cycles = 3'd3;
		end else if (op == OP_JP_HL) begin
			nxt.pc = hl;
		end else begin
			nxt = cur;
			res.status = ST_UNSUP;
		end

		res.next_pc     = nxt.pc;
		res.a_value     = nxt.a;
		res.flags_value = nxt.f;
		res.bc_value    = {nxt.b, nxt.c};
		res.de_value    = {nxt.d, nxt.e};
		res.hl_value    = {nxt.h, nxt.l};
		res.sp_value    = nxt.sp;
	end
endmodule

[src/cpu8_instruction_execute_core.sv]
// top level: instruction execute with register state and output register
//  channel | dir | word
//  in_ch   | in  | opcode, immediate, mem_data
//  out_ch  | out | status, next pc, registers, memory write, cycles
// one instruction per clock while out_ch is not stalled; result is registered and shown in the cycle after acceptance
// register state updates on acceptance, so back-to-back words see prior results
// in_ch is ready whenever the output register is empty or being drained
// reset clears the register state to zero and empties the output register (its data is not reset)
module cpu8_instruction_execute_core import cpu8_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	cpu8_stream_if.sink       in_ch,
	cpu8_stream_if.source     out_ch
);
	regs_t   regs_q, regs_d;
	result_t res_d, res_q;
	logic    vld_q, take;

	cpu8_exec u_exec (.ins(in_ch.data), .cur(regs_q), .nxt(regs_d), .res(res_d));

	assign in_ch.ready  = !vld_q || out_ch.ready;
	assign take         = in_ch.valid && in_ch.ready;
	assign out_ch.valid = vld_q;
	assign out_ch.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
			vld_q  <= 1'b0;
		end else begin
			if (take) regs_q <= regs_d;
			if (take) vld_q <= 1'b1;
			else if (out_ch.ready) vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) res_q <= res_d;
	end
endmodule

[src/cpu8_checker.sv]
// port-level checker for the execute core, bound to the top level
`include "assert_macros.svh"
module cpu8_checker import cpu8_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input result_t out_data
);
	`ASSERT_NEXT(a_accept_shows, clk, arst_n,
		in_valid && in_ready, out_valid, "accepted word not shown")
	`ASSERT_CLK(a_ready_free, clk, arst_n,
		!out_valid |-> in_ready, "stalled while output empty")
	`ASSERT_CLK(a_unsup_clean, clk, arst_n,
		(out_valid && out_data.status == ST_UNSUP) |->
		(!out_data.mem_write && out_data.machine_cycles == 3'd1),
		"unsupported word has side effects")
	`ASSERT_NEXT(a_hold, clk, arst_n,
		out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
endmodule

bind cpu8_instruction_execute_core cpu8_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
